>>> hdl/mmcs_pkg.sv
`timescale 1ns / 1ps

package mmcs_pkg;

    localparam int PIXEL_BITS_DEF = 8;
    localparam int LANES          = 3;

    typedef enum logic [1:0] {
        ACT_CLEAR   = 2'd0,
        ACT_OBSERVE = 2'd1,
        ACT_RESCALE = 2'd2
    } action_t;

    typedef enum logic [1:0] {
        ST_IDLE,
        ST_DIV,
        ST_DONE
    } state_t;

    typedef struct packed {
        logic clear;
        logic observe;
        logic start;
        logic step;
    } lane_ctrl_t;

endpackage

>>> hdl/mmcs_lane.sv
`timescale 1ns / 1ps

module mmcs_lane #(
    parameter int P = mmcs_pkg::PIXEL_BITS_DEF
) (
    input  logic                 clk,
    input  logic                 rst_n,
    input  mmcs_pkg::lane_ctrl_t ctrl,
    input  logic                 active,
    input  logic [P-1:0]         pix,
    output logic [P-1:0]         result,
    output logic                 flat
);

    localparam logic [P-1:0] FULL = {P{1'b1}};

    typedef enum logic [1:0] {
        SEL_PASS,
        SEL_ZERO,
        SEL_FULL,
        SEL_QUO
    } res_sel_t;

    logic [P-1:0]   min_reg;
    logic [P-1:0]   max_reg;

    logic [P-1:0]   diff;
    logic [2*P-1:0] prod;
    logic [P-1:0]   span;
    logic           is_flat;
    res_sel_t       sel_next;

    res_sel_t       sel_reg;
    logic           flat_reg;
    logic [P-1:0]   pass_reg;
    logic [P-1:0]   den_reg;
    logic [P-1:0]   rem_reg;
    logic [P-1:0]   num_reg;
    logic [P-1:0]   quo_reg;

    logic [P:0]     shifted;
    logic [P:0]     trial;
    logic           ge;
    logic [P-1:0]   rem_next;

    // running statistics
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            min_reg <= FULL;
            max_reg <= '0;
        end
        else if (ctrl.clear)
        begin
            min_reg <= FULL;
            max_reg <= '0;
        end
        else if (ctrl.observe && active)
        begin
            if (pix < min_reg)
            begin
                min_reg <= pix;
            end
            if (pix > max_reg)
            begin
                max_reg <= pix;
            end
        end
    end

    // numerator (v - min) * FULL, denominator max - min
    always_comb
    begin
        diff    = pix - min_reg;
        prod    = {diff, {P{1'b0}}} - {{P{1'b0}}, diff};
        span    = max_reg - min_reg;
        is_flat = (max_reg <= min_reg);
        if (!active)
        begin
            sel_next = SEL_PASS;
        end
        else if (is_flat || pix <= min_reg)
        begin
            sel_next = SEL_ZERO;
        end
        else if (pix >= max_reg)
        begin
            sel_next = SEL_FULL;
        end
        else
        begin
            sel_next = SEL_QUO;
        end
    end

    // restoring divider, one quotient bit per step
    always_comb
    begin
        shifted  = {rem_reg, num_reg[P-1]};
        trial    = shifted - {1'b0, den_reg};
        ge       = (shifted >= {1'b0, den_reg});
        rem_next = ge ? trial[P-1:0] : shifted[P-1:0];
    end

    always_ff @(posedge clk)
    begin
        if (ctrl.start)
        begin
            sel_reg  <= sel_next;
            flat_reg <= active && is_flat;
            pass_reg <= pix;
            den_reg  <= span;
            rem_reg  <= prod[2*P-1:P];
            num_reg  <= prod[P-1:0];
            quo_reg  <= '0;
        end
        else if (ctrl.step)
        begin
            rem_reg <= rem_next;
            num_reg <= {num_reg[P-2:0], 1'b0};
            quo_reg <= {quo_reg[P-2:0], ge};
        end
    end

    always_comb
    begin
        case (sel_reg)
            SEL_PASS: result = pass_reg;
            SEL_ZERO: result = '0;
            SEL_FULL: result = FULL;
            SEL_QUO:  result = quo_reg;
            default:  result = '0;
        endcase
        flat = flat_reg;
    end

endmodule

>>> hdl/mmcs_merge.sv
`timescale 1ns / 1ps

module mmcs_merge #(
    parameter int P      = mmcs_pkg::PIXEL_BITS_DEF,
    parameter int DATA_W = ((3 * P + 7) / 8) * 8
) (
    input  logic              clk,
    input  logic              rst_n,
    input  logic              load,
    input  logic              zero,
    input  logic [P-1:0]      red,
    input  logic [P-1:0]      green,
    input  logic [P-1:0]      blue,
    input  logic [2:0]        flats,
    input  logic              out_ready,
    output logic              out_valid,
    output logic [DATA_W-1:0] out_data,
    output logic              out_flag
);

    logic              valid_reg;
    logic [DATA_W-1:0] data_reg;
    logic              flag_reg;

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            valid_reg <= 1'b0;
        end
        else if (load)
        begin
            valid_reg <= 1'b1;
        end
        else if (out_ready)
        begin
            valid_reg <= 1'b0;
        end
    end

    // hold the word until taken; clear and observe give an all-zero word
    always_ff @(posedge clk)
    begin
        if (load)
        begin
            if (zero)
            begin
                data_reg <= '0;
                flag_reg <= 1'b0;
            end
            else
            begin
                data_reg <= DATA_W'({blue, green, red});
                flag_reg <= |flats;
            end
        end
    end

    assign out_valid = valid_reg;
    assign out_data  = data_reg;
    assign out_flag  = flag_reg;

endmodule

>>> hdl/min_max_contrast_stretch.sv
`timescale 1ns / 1ps

// Per-channel min/max contrast stretch on RGB pixels.
// Input words arrive on s_axis: tuser carries the action (clear statistics,
// observe pixel, rescale pixel), tdata the red, green and blue values.
// Every accepted word gives exactly one output word on m_axis: tdata carries
// the rescaled red, green and blue values, tuser the flat-channel flag.
// cfg_valid/cfg_data write colour_mode (0 grey, red only; 1 colour); write it
// only while no word is in flight. cfg_ready is always high.
// A rescale word runs a restoring divider in each of three lanes, one quotient
// bit per cycle, before its output word is loaded; the next word is accepted only
// after that word has been loaded into the output register. A clear or observe
// word needs no division and waits only for the output register to be free.
// s_axis_tready is high only while idle.
// The output word sits in a register; a finished word waits there while the
// receiver stalls, and the lanes hold their result until that register frees.
// Reset clears the statistics (min to full scale, max to zero), colour_mode to
// grey and drops any pending word.
module min_max_contrast_stretch #(
    parameter int PIXEL_BITS = mmcs_pkg::PIXEL_BITS_DEF,
    parameter int DATA_W     = ((3 * PIXEL_BITS + 7) / 8) * 8
) (
    input  logic              clk,
    input  logic              rst_n,

    input  logic              s_axis_tvalid,
    output logic              s_axis_tready,
    input  logic [DATA_W-1:0] s_axis_tdata,   // red_in, green_in, blue_in
    input  logic [1:0]        s_axis_tuser,   // action

    output logic              m_axis_tvalid,
    input  logic              m_axis_tready,
    output logic [DATA_W-1:0] m_axis_tdata,   // red_out, green_out, blue_out
    output logic [0:0]        m_axis_tuser,   // flat_flag

    input  logic              cfg_valid,
    output logic              cfg_ready,
    input  logic [0:0]        cfg_data        // colour_mode
);

    localparam int P     = PIXEL_BITS;
    localparam int CNT_W = $clog2(P);

    mmcs_pkg::state_t     state_reg;
    mmcs_pkg::state_t     state_next;
    logic [CNT_W-1:0]     count_reg;
    logic [CNT_W-1:0]     count_next;
    logic                 colour_mode_reg;
    logic                 rescale_reg;

    logic                 accept;
    logic                 load;
    logic                 last_step;
    mmcs_pkg::lane_ctrl_t ctrl;
    logic [2:0]           lane_active;
    logic [P-1:0]         lane_pix [3];
    logic [P-1:0]         lane_res [3];
    logic [2:0]           lane_flat;

    assign cfg_ready = 1'b1;

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            colour_mode_reg <= 1'b0;
        end
        else if (cfg_valid)
        begin
            colour_mode_reg <= cfg_data[0];
        end
    end

    assign accept    = s_axis_tvalid && s_axis_tready;
    assign last_step = (count_reg == CNT_W'(P - 1));

    // next state
    always_comb
    begin
        state_next = state_reg;
        count_next = count_reg;
        case (state_reg)
            mmcs_pkg::ST_IDLE:
            begin
                count_next = '0;
                if (s_axis_tvalid)
                begin
                    if (s_axis_tuser == mmcs_pkg::ACT_RESCALE)
                    begin
                        state_next = mmcs_pkg::ST_DIV;
                    end
                    else
                    begin
                        state_next = mmcs_pkg::ST_DONE;
                    end
                end
            end
            mmcs_pkg::ST_DIV:
            begin
                count_next = count_reg + 1'b1;
                if (last_step)
                begin
                    state_next = mmcs_pkg::ST_DONE;
                end
            end
            mmcs_pkg::ST_DONE:
            begin
                if (!m_axis_tvalid || m_axis_tready)
                begin
                    state_next = mmcs_pkg::ST_IDLE;
                end
            end
            default:
            begin
                state_next = mmcs_pkg::ST_IDLE;
            end
        endcase
    end

    // outputs of the sequencer
    always_comb
    begin
        s_axis_tready = 1'b0;
        load          = 1'b0;
        ctrl          = '0;
        case (state_reg)
            mmcs_pkg::ST_IDLE:
            begin
                s_axis_tready = 1'b1;
                ctrl.clear    = s_axis_tvalid && (s_axis_tuser == mmcs_pkg::ACT_CLEAR);
                ctrl.observe  = s_axis_tvalid && (s_axis_tuser == mmcs_pkg::ACT_OBSERVE);
                ctrl.start    = s_axis_tvalid && (s_axis_tuser == mmcs_pkg::ACT_RESCALE);
            end
            mmcs_pkg::ST_DIV:
            begin
                ctrl.step = 1'b1;
            end
            mmcs_pkg::ST_DONE:
            begin
                load = !m_axis_tvalid || m_axis_tready;
            end
            default:
            begin
                load = 1'b0;
            end
        endcase
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg   <= mmcs_pkg::ST_IDLE;
            count_reg   <= '0;
            rescale_reg <= 1'b0;
        end
        else
        begin
            state_reg <= state_next;
            count_reg <= count_next;
            if (accept)
            begin
                rescale_reg <= (s_axis_tuser == mmcs_pkg::ACT_RESCALE);
            end
        end
    end

    assign lane_active = {colour_mode_reg, colour_mode_reg, 1'b1};
    assign lane_pix[0] = s_axis_tdata[P-1:0];
    assign lane_pix[1] = s_axis_tdata[2*P-1:P];
    assign lane_pix[2] = s_axis_tdata[3*P-1:2*P];

    for (genvar g = 0; g < mmcs_pkg::LANES; g++)
    begin : g_lane
        mmcs_lane #(
            .P (P)
        ) u_lane (
            .clk    (clk),
            .rst_n  (rst_n),
            .ctrl   (ctrl),
            .active (lane_active[g]),
            .pix    (lane_pix[g]),
            .result (lane_res[g]),
            .flat   (lane_flat[g])
        );
    end

    mmcs_merge #(
        .P      (P),
        .DATA_W (DATA_W)
    ) u_merge (
        .clk       (clk),
        .rst_n     (rst_n),
        .load      (load),
        .zero      (!rescale_reg),
        .red       (lane_res[0]),
        .green     (lane_res[1]),
        .blue      (lane_res[2]),
        .flats     (lane_flat),
        .out_ready (m_axis_tready),
        .out_valid (m_axis_tvalid),
        .out_data  (m_axis_tdata),
        .out_flag  (m_axis_tuser[0])
    );

endmodule
